/* rtl/cfp_pkg.sv */
// Shared constants, types and field offsets of the command frame parser.
package cfp_pkg;

  // Sync header bytes
  localparam logic [7:0] HdrByte0 = 8'hFA;
  localparam logic [7:0] HdrByte1 = 8'h4D;
  localparam logic [7:0] HdrByte2 = 8'h43;
  localparam logic [7:0] HdrByte3 = 8'h55;

  // Receive buffer size; a frame is dropped when the index reaches BufferSize-5
  localparam int unsigned BufferSize = 70;

  // Command words
  localparam logic [15:0] CmdStart   = 16'h3001;
  localparam logic [15:0] CmdStop    = 16'h4001;
  localparam logic [15:0] CmdMode    = 16'h5001;
  localparam logic [15:0] CmdTrigger = 16'h5002;
  localparam logic [15:0] CmdGap     = 16'h5003;
  localparam logic [15:0] CmdReport  = 16'h6001;
  localparam logic [15:0] CmdVarIntv = 16'h8001;

  // Mode select values in payload byte 3
  localparam logic [7:0] ModeAuto   = 8'd1;
  localparam logic [7:0] ModeManual = 8'd2;

  localparam logic [15:0] MinGapReset = 16'd100;
  localparam logic [15:0] GapReset    = 16'd1000;

  localparam int unsigned SDataW = 16;
  localparam int unsigned MDataW = 88;

  // Output tdata bit positions
  localparam int unsigned OutIdLsb   = 0;
  localparam int unsigned OutLoadBit = 16;
  localparam int unsigned OutTimeLsb = 17;
  localparam int unsigned OutWorkBit = 65;
  localparam int unsigned OutManBit  = 66;
  localparam int unsigned OutTrigBit = 67;
  localparam int unsigned OutVarBit  = 68;
  localparam int unsigned OutRepBit  = 69;
  localparam int unsigned OutGapLsb  = 70;

  // Frame handed from the front to the back: payload bytes 1..8 in [0]..[7]
  typedef struct packed {
    logic            xor_ok;
    logic            locked;
    logic [7:0][7:0] payload;
  } cfp_cmd_t;

endpackage

/* rtl/cfp_front.sv */
// Front end: header hunt, length and payload capture, running XOR check.
module cfp_front
  import cfp_pkg::*;
#(
  parameter int unsigned FrameBufSize = BufferSize
)
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                time_locked_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cfp_cmd_t            q_data_o
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhHdr1  = 3'd1;
  localparam logic [2:0] PhHdr2  = 3'd2;
  localparam logic [2:0] PhHdr3  = 3'd3;
  localparam logic [2:0] PhLen   = 3'd4;
  localparam logic [2:0] PhPay   = 3'd5;
  localparam logic [2:0] PhCheck = 3'd6;

  localparam logic [6:0] AbortIdx = 7'(FrameBufSize - 5);

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      len_q, len_d;
  logic [6:0]      idx_q, idx_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0][7:0] pay_q, pay_d;
  logic [6:0]      idx_inc;
  logic [6:0]      idx_m1;
  logic            take;

  function automatic logic [2:0] hdr_step(input logic [7:0] b, input logic [7:0] want,
                                          input logic [2:0] nxt);
    logic [2:0] r;
    if (b == want) begin
      r = nxt;
    end else if (b == HdrByte0) begin
      r = PhHdr1;
    end else begin
      r = PhHunt;
    end
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign idx_inc    = idx_q + 7'd1;
  assign idx_m1     = idx_q - 7'd1;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    idx_d    = idx_q;
    xor_d    = xor_q;
    pay_d    = pay_q;
    q_push_o = 1'b0;
    q_data_o.xor_ok  = (xor_q == data_byte_i);
    q_data_o.locked  = time_locked_i;
    q_data_o.payload = pay_q;
    if (take) begin
      case (phase_q)
        PhHdr1: phase_d = hdr_step(data_byte_i, HdrByte1, PhHdr2);
        PhHdr2: phase_d = hdr_step(data_byte_i, HdrByte2, PhHdr3);
        PhHdr3: phase_d = hdr_step(data_byte_i, HdrByte3, PhLen);
        PhLen: begin
          len_d   = data_byte_i;
          idx_d   = 7'd1;
          xor_d   = data_byte_i;
          phase_d = PhPay;
        end
        PhPay: begin
          if (idx_q inside {[7'd1:7'd8]}) begin
            pay_d[idx_m1[2:0]] = data_byte_i;
          end
          xor_d = xor_q ^ data_byte_i;
          idx_d = idx_inc;
          if ({2'b00, idx_inc} >= ({1'b0, len_q} + 9'd1)) begin
            phase_d = PhCheck;
          end
          if (idx_inc >= AbortIdx) begin
            phase_d = PhHunt;
          end
        end
        PhCheck: begin
          q_push_o = 1'b1;
          phase_d  = PhHunt;
        end
        default: phase_d = (data_byte_i == HdrByte0) ? PhHdr1 : PhHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      idx_q   <= '0;
      xor_q   <= '0;
      pay_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
      pay_q   <= pay_d;
    end
  end

endmodule

/* rtl/cfp_queue.sv */
// Two-entry queue of finished frames between front and back.
module cfp_queue
  import cfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cfp_cmd_t push_data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output cfp_cmd_t pop_data_o
);

  cfp_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/cfp_back.sv */
// Back end: command decode, mode/gap state and the output register.
module cfp_back
  import cfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  cfp_cmd_t          q_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MDataW-1:0] out_data_o,
  output logic              out_user_o
);

  logic [15:0]       min_gap_val_q;
  logic              work_q, work_d;
  logic              man_q, man_d;
  logic [15:0]       gap_q, gap_d;
  logic              out_valid_q;
  logic [MDataW-1:0] out_data_q, out_data_d;
  logic              out_user_q, out_user_d;
  logic [15:0]       cmd_id;
  logic [15:0]       gap_req;
  logic              load, trig, varq, rep;
  logic [47:0]       tv;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_id  = {q_data_i.payload[0], q_data_i.payload[1]};
  assign gap_req = {q_data_i.payload[3], q_data_i.payload[2]};

  always_comb begin
    work_d = work_q;
    man_d  = man_q;
    gap_d  = gap_q;
    load   = 1'b0;
    trig   = 1'b0;
    varq   = 1'b0;
    rep    = 1'b0;
    tv     = '0;
    if (q_data_i.xor_ok) begin
      case (cmd_id)
        CmdStart: begin
          if (!q_data_i.locked) begin
            load = 1'b1;
            tv   = {q_data_i.payload[2], q_data_i.payload[3], q_data_i.payload[4],
                    q_data_i.payload[5], q_data_i.payload[6], q_data_i.payload[7]};
          end
          work_d = 1'b1;
        end
        CmdStop: work_d = 1'b0;
        CmdMode: begin
          if (!work_q) begin
            if (q_data_i.payload[2] == ModeAuto) begin
              man_d = 1'b0;
            end else if (q_data_i.payload[2] == ModeManual) begin
              man_d = 1'b1;
            end
          end
        end
        CmdTrigger: trig = work_q && man_q;
        CmdReport:  rep  = 1'b1;
        CmdVarIntv: varq = 1'b1;
        CmdGap:     gap_d = (gap_req < min_gap_val_q) ? min_gap_val_q : gap_req;
        default:    ;
      endcase
    end
    out_user_d = q_data_i.xor_ok;
    out_data_d = '0;
    out_data_d[OutIdLsb +: 16]   = q_data_i.xor_ok ? cmd_id : 16'd0;
    out_data_d[OutLoadBit]       = load;
    out_data_d[OutTimeLsb +: 48] = tv;
    out_data_d[OutWorkBit]       = work_d;
    out_data_d[OutManBit]        = man_d;
    out_data_d[OutTrigBit]       = trig;
    out_data_d[OutVarBit]        = varq;
    out_data_d[OutRepBit]        = rep;
    out_data_d[OutGapLsb +: 16]  = gap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_val_q <= MinGapReset;
      work_q        <= 1'b0;
      man_q         <= 1'b0;
      gap_q         <= GapReset;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_gap_val_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        work_q      <= work_d;
        man_q       <= man_d;
        gap_q       <= gap_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

/* rtl/command_frame_parser.sv */
// Top level of the command frame parser.
//
// Input stream (s_axis): one received serial byte per item plus the time
// lock flag. The front end hunts for the FA 4D 43 55 header, reads the
// length and payload bytes and checks the XOR on the byte that follows.
// Only that check byte produces an item on the output stream (m_axis):
// tuser carries frame_valid, tdata the decoded command and the state after it.
// cfg_we_i/cfg_wdata_i write the minimum pulse gap (reset value 100).
//
// Throughput: one input byte per cycle while the frame queue is not full.
// On its way to m_axis a result is registered first in the two-entry frame
// queue, then, through command decode, in the output register.
// A stalled receiver fills the output register, then the queue; once the
// queue is full s_axis_tready drops until the output side drains.
// Reset (async, active low) returns to header hunt, clears payload bytes,
// flags and queue, and sets pulse gap 1000.
module command_frame_parser
  import cfp_pkg::*;
#(
  parameter int unsigned FrameBufSize = BufferSize
)
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] data_byte, [8] time_locked
  input  logic [SDataW-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] command_id, [16] load_time, [64:17] time_value, [65] working,
  // [66] manual_mode, [67] trigger_request, [68] variable_interval_request,
  // [69] report_mode_request, [85:70] pulse_gap
  output logic [MDataW-1:0] m_axis_tdata,
  // [0] frame_valid
  output logic              m_axis_tuser
);

  logic     q_push, q_full, q_valid, q_pop;
  cfp_cmd_t q_in, q_out;

  cfp_front #(
    .FrameBufSize (FrameBufSize)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .data_byte_i   (s_axis_tdata[7:0]),
    .time_locked_i (s_axis_tdata[8]),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  cfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_out)
  );

  cfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

/* rtl/cfp_checker.sv */
// Port-level checks on the command frame parser, bound to the top level.
module cfp_checker
  import cfp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  // A stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // Bad check byte: no command fields or pulses
  a_bad_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[64:0] == 65'd0 && m_axis_tdata[69:67] == 3'd0)
    else $error("rejected frame carries command output");

  // Trigger only fires while working in manual mode
  a_trig_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[65] && m_axis_tdata[66])
    else $error("trigger outside working manual mode");

  // Time load only from a start command, which sets working
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |->
      m_axis_tdata[15:0] == CmdStart && m_axis_tdata[65])
    else $error("time load without start command");

  // Nonzero time value only with load_time
  a_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[64:17] == 48'd0)
    else $error("time value without load");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/command_frame_parser_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for command_frame_parser: random framed byte streams vs a built-in decoder.
module command_frame_parser_tb;
  import cfp_pkg::*;

  localparam int unsigned QuietFrom  = 1100;  // both sides run without idling here
  localparam int unsigned QuietTo    = 1500;
  localparam int unsigned HoldAt     = 450;   // receiver backpressure window
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned PhaseItems = 270;
  localparam int unsigned MaxPrinted = 40;

  typedef enum logic [2:0] {
    PhHunt, PhSawFa, PhSaw4d, PhSaw43, PhLength, PhPayload, PhCheck
  } rx_phase_e;

  typedef struct packed {
    logic       locked;
    logic [7:0] data;
  } rx_byte_t;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] command_id;
    logic        load_time;
    logic [47:0] time_value;
    logic        working;
    logic        manual_mode;
    logic        trigger_req;
    logic        var_intv_req;
    logic        report_req;
    logic [15:0] pulse_gap;
  } decoded_cmd_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [15:0]       cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic [SDataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tready = 1'b0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [MDataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  rx_byte_t     byte_q [$];
  decoded_cmd_t cmd_q [$];
  logic [7:0]   frame_buf [64];
  int unsigned  cyc        = 0;
  int unsigned  stim_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  hold_left  = 0;

  // decoder model state
  rx_phase_e   mdl_phase   = PhHunt;
  logic [7:0]  mdl_len     = '0;
  logic [6:0]  mdl_idx     = '0;
  logic [7:0]  mdl_xor     = '0;
  logic [7:0]  mdl_pay [8] = '{default: 8'h00};
  logic        mdl_working = 1'b0;
  logic        mdl_manual  = 1'b0;
  logic [15:0] mdl_gap     = GapReset;
  logic [15:0] min_gap     = MinGapReset;

  command_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic rx_phase_e header_next(input logic [7:0] b, input logic [7:0] want,
                                            input rx_phase_e nxt);
    if (b == want) return nxt;
    if (b == HdrByte0) return PhSawFa;
    return PhHunt;
  endfunction

  // Advance the decoder model by one accepted byte; a check byte queues one result.
  function automatic void track_rx_byte(input logic [7:0] b, input logic locked);
    decoded_cmd_t r;
    logic [15:0]  v;
    r = '0;
    case (mdl_phase)
      PhSawFa: mdl_phase = header_next(b, HdrByte1, PhSaw4d);
      PhSaw4d: mdl_phase = header_next(b, HdrByte2, PhSaw43);
      PhSaw43: mdl_phase = header_next(b, HdrByte3, PhLength);
      PhLength: begin
        mdl_len   = b;
        mdl_idx   = 7'd1;
        mdl_xor   = b;
        mdl_phase = PhPayload;
      end
      PhPayload: begin
        if (mdl_idx >= 7'd1 && mdl_idx <= 7'd8) mdl_pay[mdl_idx - 7'd1] = b;
        mdl_xor ^= b;
        mdl_idx = mdl_idx + 7'd1;
        if (int'(mdl_idx) >= int'(mdl_len) + 1) mdl_phase = PhCheck;
        // abort wins over a completed payload
        if (int'(mdl_idx) >= int'(BufferSize) - 5) mdl_phase = PhHunt;
      end
      PhCheck: begin
        mdl_phase = PhHunt;
        if (mdl_xor == b) begin
          r.frame_valid = 1'b1;
          r.command_id  = {mdl_pay[0], mdl_pay[1]};
          case (r.command_id)
            CmdStart: begin
              if (!locked) begin
                r.load_time  = 1'b1;
                r.time_value = {mdl_pay[2], mdl_pay[3], mdl_pay[4],
                                mdl_pay[5], mdl_pay[6], mdl_pay[7]};
              end
              mdl_working = 1'b1;
            end
            CmdStop: mdl_working = 1'b0;
            CmdMode: begin
              if (!mdl_working) begin
                if (mdl_pay[2] == ModeAuto) mdl_manual = 1'b0;
                else if (mdl_pay[2] == ModeManual) mdl_manual = 1'b1;
              end
            end
            CmdTrigger: r.trigger_req = mdl_working && mdl_manual;
            CmdReport: r.report_req = 1'b1;
            CmdVarIntv: r.var_intv_req = 1'b1;
            CmdGap: begin
              v = {mdl_pay[3], mdl_pay[2]};
              mdl_gap = (v < min_gap) ? min_gap : v;
            end
            default: ;
          endcase
        end
        r.working     = mdl_working;
        r.manual_mode = mdl_manual;
        r.pulse_gap   = mdl_gap;
        cmd_q.push_back(r);
      end
      default: mdl_phase = (b == HdrByte0) ? PhSawFa : PhHunt;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit pin, input bit lk);
    rx_byte_t it;
    it.data   = b;
    it.locked = pin ? lk : 1'($urandom_range(1));
    byte_q.push_back(it);
    stim_count++;
  endtask

  // Header, length, payload from frame_buf, then the check byte unless the frame aborts.
  task automatic send_frame(input int len, input bit good, input bit pin, input bit lk);
    logic [7:0] x;
    int         n;
    push_byte(HdrByte0, 0, 0);
    push_byte(HdrByte1, 0, 0);
    push_byte(HdrByte2, 0, 0);
    push_byte(HdrByte3, 0, 0);
    push_byte(8'(len), 0, 0);
    x = 8'(len);
    n = (len + 1 > 64) ? 64 : len + 1;
    for (int i = 0; i < n; i++) begin
      push_byte(frame_buf[i], 0, 0);
      x ^= frame_buf[i];
    end
    if (len < 64) push_byte(good ? x : x ^ 8'($urandom_range(1, 255)), pin, lk);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min_gap(input logic [15:0] g);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_gap = g;
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    rx_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_rx_byte(s_axis_tdata[7:0], s_axis_tdata[8]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 &&
            ((cyc >= QuietFrom && cyc < QuietTo) || $urandom_range(99) >= 24)) begin
          nxt = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(SDataW - 9){1'b0}}, nxt.locked, nxt.data};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_cmd_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          flag_mismatch("result with none expected", m_axis_tdata[63:0], '0);
        end else begin
          want = cmd_q.pop_front();
          if (m_axis_tuser !== want.frame_valid)
            flag_mismatch("frame_valid", m_axis_tuser, want.frame_valid);
          if (m_axis_tdata[OutIdLsb +: 16] !== want.command_id)
            flag_mismatch("command_id", m_axis_tdata[OutIdLsb +: 16], want.command_id);
          if (m_axis_tdata[OutLoadBit] !== want.load_time)
            flag_mismatch("load_time", m_axis_tdata[OutLoadBit], want.load_time);
          if (m_axis_tdata[OutTimeLsb +: 48] !== want.time_value)
            flag_mismatch("time_value", m_axis_tdata[OutTimeLsb +: 48], want.time_value);
          if (m_axis_tdata[OutWorkBit] !== want.working)
            flag_mismatch("working", m_axis_tdata[OutWorkBit], want.working);
          if (m_axis_tdata[OutManBit] !== want.manual_mode)
            flag_mismatch("manual_mode", m_axis_tdata[OutManBit], want.manual_mode);
          if (m_axis_tdata[OutTrigBit] !== want.trigger_req)
            flag_mismatch("trigger_request", m_axis_tdata[OutTrigBit], want.trigger_req);
          if (m_axis_tdata[OutVarBit] !== want.var_intv_req)
            flag_mismatch("variable_interval_request", m_axis_tdata[OutVarBit],
                          want.var_intv_req);
          if (m_axis_tdata[OutRepBit] !== want.report_req)
            flag_mismatch("report_mode_request", m_axis_tdata[OutRepBit], want.report_req);
          if (m_axis_tdata[OutGapLsb +: 16] !== want.pulse_gap)
            flag_mismatch("pulse_gap", m_axis_tdata[OutGapLsb +: 16], want.pulse_gap);
          if (m_axis_tdata[MDataW-1:OutGapLsb+16] !== '0)
            flag_mismatch("tdata padding", m_axis_tdata[MDataW-1:OutGapLsb+16], '0);
        end
      end
      if (cyc == HoldAt) hold_left = HoldLen;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (cyc >= QuietFrom && cyc < QuietTo) || $urandom_range(99) >= 24;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned k;
    int          len;
    logic [15:0] id;
    logic [15:0] v;
    logic [15:0] g;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // repeated FA inside the header, then a start with unlocked time at the byte extremes
    push_byte(HdrByte0, 0, 0);
    frame_buf[0] = CmdStart[15:8];
    frame_buf[1] = CmdStart[7:0];
    frame_buf[2] = 8'hFF;
    frame_buf[3] = 8'h00;
    frame_buf[4] = 8'hFF;
    frame_buf[5] = 8'h00;
    frame_buf[6] = 8'hFF;
    frame_buf[7] = 8'h00;
    send_frame(7, 1, 1, 0);
    // zero length: one payload byte, second id byte stale; bad check byte
    frame_buf[0] = 8'hAB;
    send_frame(0, 0, 1, 1);

    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        wait_drained();
        case (p)
          1: g = 16'hFFFF;
          2: g = 16'h0000;
          3: g = 16'($urandom);
          default: g = 16'd1;
        endcase
        write_min_gap(g);
      end
      stim_count = 0;
      while (stim_count < PhaseItems) begin
        for (int i = 0; i < 64; i++) frame_buf[i] = 8'($urandom);
        sel = $urandom_range(99);
        if (sel < 80) begin
          case ($urandom_range(7))
            0: id = CmdStart;
            1: id = CmdStop;
            2: id = CmdMode;
            3: id = CmdTrigger;
            4: id = CmdReport;
            5: id = CmdVarIntv;
            6: id = CmdGap;
            default: id = 16'($urandom);
          endcase
          frame_buf[0] = id[15:8];
          frame_buf[1] = id[7:0];
          if (id == CmdMode) begin
            k = $urandom_range(2);
            frame_buf[2] = (k == 0) ? ModeAuto : (k == 1) ? ModeManual : 8'($urandom);
          end
          if (id == CmdGap) begin
            case ($urandom_range(4))
              0: v = 16'($urandom_range(200));
              1: v = min_gap + 16'($urandom_range(2)) - 16'd1;
              2: v = 16'h0000;
              3: v = 16'hFFFF;
              default: v = 16'($urandom);
            endcase
            frame_buf[2] = v[7:0];
            frame_buf[3] = v[15:8];
          end
          sel = $urandom_range(99);
          if (sel < 70)
            len = (id == CmdStart) ? 7 : (id == CmdGap) ? 3 : (id == CmdMode) ? 2 : 1;
          else if (sel < 92)
            len = $urandom_range(9);
          else
            len = $urandom_range(10, 63);
          send_frame(len, $urandom_range(99) < 85, 0, 0);
        end else if (sel < 88) begin
          repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(3) == 0) ? HdrByte0 : 8'($urandom), 0, 0);
        end else if (sel < 96) begin
          // header cut short by a wrong byte, often a fresh FA
          push_byte(HdrByte0, 0, 0);
          k = $urandom_range(2);
          if (k >= 1) push_byte(HdrByte1, 0, 0);
          if (k >= 2) push_byte(HdrByte2, 0, 0);
          push_byte($urandom_range(1) ? HdrByte0 : 8'($urandom), 0, 0);
        end else begin
          // length past the buffer: the frame aborts mid-payload
          send_frame($urandom_range(64, 255), 1, 0, 0);
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("command_frame_parser: match");
    end else begin
      $display("command_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("command_frame_parser: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_queue.sv
rtl/cfp_back.sv
rtl/command_frame_parser.sv
rtl/cfp_checker.sv
dv/command_frame_parser_tb.sv
